### hdl/big_endian_byte_ring_fifo_macros.svh
// Assertion macros used by the byte ring FIFO top level.
`ifndef BIG_ENDIAN_BYTE_RING_FIFO_MACROS_SVH
`define BIG_ENDIAN_BYTE_RING_FIFO_MACROS_SVH

// Check a consequence in the same cycle as its condition.
`define BEBRF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its condition.
`define BEBRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/bebrf_pkg.sv
// Package with item types and constants of the byte ring FIFO.
package bebrf_pkg;

   localparam int CAPACITY_DEFAULT = 4096;

   localparam int KIND_W    = 2;
   localparam int WCODE_W   = 2;
   localparam int VALUE_W   = 64;
   localparam int MOVED_W   = 4;
   localparam int FILL_W    = 13;
   localparam int BYTE_W    = 8;

   localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PEEK = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SKIP = 2'd3;

   localparam logic [WCODE_W-1:0] WCODE_1 = 2'd0;
   localparam logic [WCODE_W-1:0] WCODE_2 = 2'd1;
   localparam logic [WCODE_W-1:0] WCODE_4 = 2'd2;
   localparam logic [WCODE_W-1:0] WCODE_8 = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [WCODE_W-1:0] width_code;
      logic [VALUE_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] read_value;
      logic [MOVED_W-1:0] bytes_moved;
      logic               overflow;
      logic [FILL_W-1:0]  fill_level;
   } rsp_type;

endpackage

### hdl/bebrf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bebrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read ports, read data is registered and lands in the cycle after the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/big_endian_byte_ring_fifo.sv
// Top level of the circular byte FIFO with big-endian multi-byte access.
//
//   channel   ports                          direction   moves
//   request   req_valid req_stall req_data   in          push, pop, peek, skip item
//   response  rsp_valid rsp_stall rsp_data   out         one result item per request
//
// One item at a time, one byte per cycle through the byte-wide RAM ports.
// A push of S bytes writes all of them, or none on overflow. Pop, peek or skip
// moves N bytes, the fewer of the item size and the stored bytes, then the result.
// Reset clears pointers and count; the byte RAM is not cleared.
// A stalled result waits in the output register; the next item is taken meanwhile
// and finishes once that register is free.
module big_endian_byte_ring_fifo
   import bebrf_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

`include "big_endian_byte_ring_fifo_macros.svh"

   localparam int PTR_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int SIZE_W = 4;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_PUSH = 4'b0010,
      ST_READ = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [SIZE_W-1:0]    size_ff, size_in;
   logic [SIZE_W-1:0]    num_ff, num_in;
   logic [SIZE_W-1:0]    idx_ff, idx_in;
   logic [VALUE_W-1:0]   val_ff, val_in;
   logic [VALUE_W-1:0]   acc_ff, acc_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic                 ovf_ff, ovf_in;
   logic [PTR_W-1:0]     head_ff, head_in;
   logic [PTR_W-1:0]     tail_ff, tail_in;
   logic [PTR_W-1:0]     walk_ff, walk_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 req_accept;
   logic [SIZE_W-1:0]    req_size;
   logic [CNT_W-1:0]     free_space;
   logic                 mem_wr_en;
   logic                 mem_rd_en;
   logic [BYTE_W-1:0]    mem_rd_data;
   logic                 out_free;
   logic [SIZE_W-1:0]    pad_bytes;
   logic [SUM_W-1:0]     chk_sum;
   logic [SUM_W-1:0]     chk_wrap;

   // Advance a pointer with wrap at the capacity
   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(CAPACITY - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   assign req_size   = SIZE_W'(1) << req_data.width_code;
   assign free_space = CNT_W'(CAPACITY) - count_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign pad_bytes  = size_ff - num_ff;

   assign mem_wr_en  = (state_ff == ST_PUSH);
   assign mem_rd_en  = (state_ff == ST_READ) && (idx_ff != num_ff);

   bebrf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (tail_ff),
      .wr_data (val_ff[VALUE_W-1 -: BYTE_W]),
      .rd_en   (mem_rd_en),
      .rd_addr (walk_ff),
      .rd_data (mem_rd_data)
   );

   // Sequence one item: accept, move bytes, deliver the result
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      size_in      = size_ff;
      num_in       = num_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      acc_in       = acc_ff;
      rd_pend_in   = 1'b0;
      ovf_in       = ovf_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      walk_in      = walk_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               kind_in = req_data.kind;
               size_in = req_size;
               idx_in  = '0;
               acc_in  = '0;
               walk_in = head_ff;
               ovf_in  = 1'b0;
               if (count_ff < CNT_W'(req_size)) begin
                  num_in = count_ff[SIZE_W-1:0];
               end else begin
                  num_in = req_size;
               end
               // Align the pushed value so its first byte sits on top
               case (req_data.width_code)
                  WCODE_1: val_in = {req_data.push_value[7:0], 56'd0};
                  WCODE_2: val_in = {req_data.push_value[15:0], 48'd0};
                  WCODE_4: val_in = {req_data.push_value[31:0], 32'd0};
                  default: val_in = req_data.push_value;
               endcase
               if (req_data.kind == KIND_PUSH) begin
                  if (CNT_W'(req_size) > free_space) begin
                     ovf_in   = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_PUSH;
                  end
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_PUSH: begin
            // Write one byte, advance tail
            tail_in = ptr_next(tail_ff);
            val_in  = val_ff << BYTE_W;
            idx_in  = idx_ff + 1'b1;
            if (idx_ff + 1'b1 == size_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            // Issue one read a cycle, collect its data in the following cycle
            if (mem_rd_en) begin
               walk_in    = ptr_next(walk_ff);
               idx_in     = idx_ff + 1'b1;
               rd_pend_in = 1'b1;
            end
            if (rd_pend_ff) begin
               acc_in = {acc_ff[VALUE_W-BYTE_W-1:0], mem_rd_data};
            end
            if (!mem_rd_en && !rd_pend_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold until the output register is free
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.overflow     = ovf_ff;
               rsp_in.read_value   = '0;
               rsp_in.bytes_moved  = '0;
               count_in            = count_ff;
               case (kind_ff)
                  KIND_PUSH: begin
                     if (!ovf_ff) begin
                        count_in           = count_ff + CNT_W'(size_ff);
                        rsp_in.bytes_moved = size_ff;
                     end
                  end
                  KIND_POP: begin
                     count_in           = count_ff - CNT_W'(num_ff);
                     head_in            = walk_ff;
                     rsp_in.bytes_moved = num_ff;
                     rsp_in.read_value  = acc_ff << {pad_bytes, 3'b000};
                  end
                  KIND_PEEK: begin
                     rsp_in.bytes_moved = num_ff;
                     rsp_in.read_value  = acc_ff << {pad_bytes, 3'b000};
                  end
                  default: begin
                     count_in           = count_ff - CNT_W'(num_ff);
                     head_in            = walk_ff;
                     rsp_in.bytes_moved = num_ff;
                  end
               endcase
               rsp_in.fill_level = FILL_W'(count_in);
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_pend_ff   <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      size_ff <= size_in;
      num_ff  <= num_in;
      idx_ff  <= idx_in;
      val_ff  <= val_in;
      acc_ff  <= acc_in;
      ovf_ff  <= ovf_in;
      walk_ff <= walk_in;
      rsp_ff  <= rsp_in;
   end

   // Head plus count, wrapped, must meet the tail between items
   assign chk_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign chk_wrap = (chk_sum >= SUM_W'(CAPACITY)) ? chk_sum - SUM_W'(CAPACITY) : chk_sum;

   `BEBRF_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY), "count above capacity")
   `BEBRF_ASSERT_NOW(a_ptr_consistent, clock, reset, state_ff == ST_IDLE, chk_wrap == SUM_W'(tail_ff), "head count tail mismatch")
   `BEBRF_ASSERT_NOW(a_port_exclusive, clock, reset, mem_wr_en, !mem_rd_en, "RAM read and write overlap")
   `BEBRF_ASSERT_NEXT(a_accept_busy, clock, reset, req_accept, state_ff != ST_IDLE, "accepted item left no work")
   `BEBRF_ASSERT_NOW(a_ovf_nothing_moved, clock, reset, rsp_valid_ff && rsp_ff.overflow, rsp_ff.bytes_moved == '0, "overflow with bytes moved")

endmodule
